>>> rtl/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

  // Capacity of the list and the widths that follow from it
  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_POP_FRONT  = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_REMOVE     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        count_t;
  typedef logic signed [DW-1:0] word_t;

endpackage

>>> rtl/bdq_if.sv
`timescale 1ns / 1ps

// Request channel: opcode and value
interface bdq_in_if;
  logic             valid;
  logic             ready;
  bdq_pkg::opcode_t opcode;
  bdq_pkg::word_t   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

// Response channel: status, word taken out and new length
interface bdq_out_if;
  logic             valid;
  logic             ready;
  bdq_pkg::status_t status;
  bdq_pkg::word_t   removed_value;
  bdq_pkg::count_t  length;

  modport source (output valid, output status, output removed_value, output length,
                  input ready);
  modport sink   (input valid, input status, input removed_value, input length,
                  output ready);
endinterface

>>> rtl/bounded_deque_with_remove.sv
`timescale 1ns / 1ps

// Bounded double-ended list of signed 32-bit words with remove by value.
// in_req carries one request word (opcode, value) on a valid/ready handshake;
// out_rsp returns exactly one response word (status, removed_value, length)
// per request, in request order.
// The entries live in a single-port-write, registered-read memory of DEPTH
// words used as a circular buffer; front position and count are registers.
// Steps from acceptance to the response register:
//   push, pop on an empty list, remove on an empty list: straight to S_DONE
//   pop front / pop back: S_POP (one memory read), then S_DONE
//   remove: S_SCAN over m entries, then S_SHIFT over s, where m is the number
//   of entries scanned up to and including the match (or the whole length) and
//   s the entries moved to close the gap; m + s never exceeds the length.
//   The scan and the shift each move one entry per cycle through the read port.
// One request is worked on at a time; the next is accepted from the cycle after
// the previous one reaches the response register, even while that response
// still waits. If out_rsp.ready is low, the response holds and the block
// stops before offering the next one. Synchronous active-low reset empties
// the list; memory contents are not cleared and need no clearing pass.
module bounded_deque_with_remove (
  input  logic clk,
  input  logic rst_n,
  bdq_in_if.sink    in_req,
  bdq_out_if.source out_rsp
);
  import bdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  localparam count_t DEPTH_C = CW'(DEPTH);

  // Store position of the entry k places behind the front
  function automatic addr_t slot_of(addr_t front, count_t k);
    logic [CW:0] p;
    begin
      p = {{(CW + 1 - AW){1'b0}}, front} + {1'b0, k};
      if (p >= (CW + 1)'(DEPTH)) begin
        p = p - (CW + 1)'(DEPTH);
      end
      return p[AW-1:0];
    end
  endfunction

  // Control and working registers
  state_t  state_r, state_nxt;
  addr_t   front_r, front_nxt;
  count_t  count_r, count_nxt;
  count_t  idx_r, idx_nxt;
  opcode_t op_r, op_nxt;
  word_t   val_r, val_nxt;
  status_t res_status_r, res_status_nxt;
  word_t   res_removed_r, res_removed_nxt;

  // Response register
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  word_t   out_removed_r, out_removed_nxt;
  count_t  out_length_r, out_length_nxt;

  // Entry memory
  word_t   mem [DEPTH];
  word_t   rdata_r;
  logic    rd_en;
  addr_t   rd_addr;
  logic    wr_en;
  addr_t   wr_addr;
  word_t   wr_data;

  logic    accept;
  logic    out_load;
  addr_t   front_dec;

  assign accept    = in_req.valid && in_req.ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);
  assign front_dec = (front_r == '0) ? AW'(DEPTH - 1) : front_r - 1'b1;

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.removed_value = out_removed_r;
  assign out_rsp.length        = out_length_r;

  // Sequence one request through the memory
  always_comb begin
    state_nxt       = state_r;
    front_nxt       = front_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    op_nxt          = op_r;
    val_nxt         = val_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    rd_en           = 1'b0;
    rd_addr         = front_r;
    wr_en           = 1'b0;
    wr_addr         = front_dec;
    wr_data         = in_req.value;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt          = in_req.opcode;
          val_nxt         = in_req.value;
          res_status_nxt  = ST_OK;
          res_removed_nxt = '0;
          idx_nxt         = '0;
          state_nxt       = S_DONE;
          unique case (in_req.opcode)
            OP_PUSH_FRONT: begin
              if (count_r >= DEPTH_C) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_POP;
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = slot_of(front_r, count_r - 1'b1);
                state_nxt = S_POP;
              end
            end
            default: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOTFOUND;
              end else begin
                rd_en     = 1'b1;
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end

      S_POP: begin
        res_removed_nxt = rdata_r;
        count_nxt       = count_r - 1'b1;
        if (op_r == OP_POP_FRONT) begin
          front_nxt = slot_of(front_r, CW'(1));
        end
        state_nxt = S_DONE;
      end

      // rdata_r holds the entry at idx_r; fetch the one behind it meanwhile
      S_SCAN: begin
        rd_addr = slot_of(front_r, idx_r + 1'b1);
        if (rdata_r == val_r) begin
          res_removed_nxt = rdata_r;
          if ({1'b0, idx_r} + 1'b1 < {1'b0, count_r}) begin
            rd_en     = 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_DONE;
          end
        end else if ({1'b0, idx_r} + 1'b1 < {1'b0, count_r}) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          res_status_nxt = ST_NOTFOUND;
          state_nxt      = S_DONE;
        end
      end

      // rdata_r holds the entry at idx_r + 1; move it down one place
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(front_r, idx_r);
        wr_data = rdata_r;
        rd_addr = slot_of(front_r, idx_r + 2'd2);
        if ({1'b0, idx_r} + 2'd2 < {1'b0, count_r}) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load the response register and drop it once taken
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_rsp.ready;
    out_status_nxt  = out_status_r;
    out_removed_nxt = out_removed_r;
    out_length_nxt  = out_length_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = res_status_r;
      out_removed_nxt = res_removed_r;
      out_length_nxt  = count_r;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    op_r          <= op_nxt;
    val_r         <= val_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_removed_r <= out_removed_nxt;
    out_length_r  <= out_length_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/bdq_chk.sv
`timescale 1ns / 1ps

module bdq_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input bdq_pkg::status_t out_status,
  input bdq_pkg::word_t   out_removed_value,
  input bdq_pkg::count_t  out_length
);
  import bdq_pkg::*;

  // Length never exceeds the capacity
  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_length <= CW'(DEPTH)))
    else $error("length above capacity");

  // Refused requests take nothing out
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_removed_value == '0))
    else $error("refused request returned a word");

  // A full refusal only happens at capacity
  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_length == CW'(DEPTH)))
    else $error("full status with spare room");

  // An empty refusal only happens with nothing held
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_length == '0))
    else $error("empty status with entries held");

  // A stalled response word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_removed_value) && $stable(out_length)))
    else $error("stalled response changed");

endmodule

bind bounded_deque_with_remove bdq_chk u_bdq_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_rsp.valid),
  .out_ready         (out_rsp.ready),
  .out_status        (out_rsp.status),
  .out_removed_value (out_rsp.removed_value),
  .out_length        (out_rsp.length)
);
